@@ rtl/i2cbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbfs_pkg
// Types and segment tables for the I2C byte frame sequencer.
// ----------------------------------------------------------------------------
package i2cbfs_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    SEG_START = 3'd0,
    SEG_WBYTE = 3'd1,
    SEG_ACK   = 3'd2,
    SEG_READ  = 3'd3,
    SEG_NACK  = 3'd4,
    SEG_STOP  = 3'd5
  } seg_kind_t;

  typedef enum logic [1:0] {
    SRC_ADDR    = 2'd0,
    SRC_REG     = 2'd1,
    SRC_DATA    = 2'd2,
    SRC_ADDR_RD = 2'd3
  } seg_src_t;

  typedef struct packed {
    seg_kind_t kind;
    seg_src_t  src;
  } segment_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_address;
    logic [7:0] memory_address;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

  localparam logic [3:0] WR_LAST_SEG = 4'd7;
  localparam logic [3:0] RD_LAST_SEG = 4'd10;

  // Segment list of each frame
  function automatic segment_t seg_lookup(input logic is_read, input logic [3:0] idx);
    segment_t s;
    s = '{kind: SEG_STOP, src: SRC_ADDR};
    if (!is_read) begin
      unique case (idx)
        4'd0:    s = '{kind: SEG_START, src: SRC_ADDR};
        4'd1:    s = '{kind: SEG_WBYTE, src: SRC_ADDR};
        4'd2:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        4'd3:    s = '{kind: SEG_WBYTE, src: SRC_REG};
        4'd4:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        4'd5:    s = '{kind: SEG_WBYTE, src: SRC_DATA};
        4'd6:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        default: s = '{kind: SEG_STOP,  src: SRC_ADDR};
      endcase
    end else begin
      unique case (idx)
        4'd0:    s = '{kind: SEG_START, src: SRC_ADDR};
        4'd1:    s = '{kind: SEG_WBYTE, src: SRC_ADDR};
        4'd2:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        4'd3:    s = '{kind: SEG_WBYTE, src: SRC_REG};
        4'd4:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        4'd5:    s = '{kind: SEG_START, src: SRC_ADDR};
        4'd6:    s = '{kind: SEG_WBYTE, src: SRC_ADDR_RD};
        4'd7:    s = '{kind: SEG_ACK,   src: SRC_ADDR};
        4'd8:    s = '{kind: SEG_READ,  src: SRC_ADDR};
        4'd9:    s = '{kind: SEG_NACK,  src: SRC_ADDR};
        default: s = '{kind: SEG_STOP,  src: SRC_ADDR};
      endcase
    end
    return s;
  endfunction

  // Offset of the final phase within a segment
  function automatic logic [4:0] seg_last_off(input seg_kind_t kind);
    logic [4:0] n;
    unique case (kind)
      SEG_START: n = 5'd2;
      SEG_WBYTE: n = 5'd23;
      SEG_ACK:   n = 5'd7;
      SEG_READ:  n = 5'd15;
      SEG_NACK:  n = 5'd2;
      SEG_STOP:  n = 5'd3;
      default:   n = 5'd3;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/i2cbfs_if.sv @@
// ----------------------------------------------------------------------------
// i2cbfs_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface i2cbfs_req_if;
  logic                valid;
  logic                ready;
  i2cbfs_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cbfs_res_if;
  logic                valid;
  logic                ready;
  i2cbfs_pkg::res_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/i2cbfs_core.sv @@
// ----------------------------------------------------------------------------
// i2cbfs_core
// Frame state, phase timer and pin drive; one step per accepted item.
// ----------------------------------------------------------------------------
module i2cbfs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              adv,
  input  i2cbfs_pkg::req_t  item,
  output i2cbfs_pkg::res_t  result
);
  import i2cbfs_pkg::*;

  logic [15:0] ticks_per_phase;
  logic        busy, busy_next;
  logic        is_read, is_read_next;
  logic [7:0]  addr_b, addr_b_next;
  logic [7:0]  reg_b, reg_b_next;
  logic [7:0]  data_b, data_b_next;
  logic [7:0]  rx_b, rx_b_next;
  logic [15:0] tick_cnt, tick_cnt_next;
  logic [3:0]  seg_idx, seg_idx_next;
  logic [4:0]  seg_off, seg_off_next;
  logic [1:0]  slot, slot_next;
  logic [2:0]  bit_cnt, bit_cnt_next;
  logic        scl, scl_next;
  logic        sda, sda_next;

  logic        start, step, done, seg_end;
  logic [15:0] limit, tick_inc;
  logic [1:0]  slot_max;
  logic [2:0]  bit_sel;
  logic [7:0]  src_byte;
  segment_t    cur_seg, new_seg;

  assign limit    = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
  assign tick_inc = tick_cnt + 16'd1;
  assign start    = !busy && (item.kind == KIND_WRITE || item.kind == KIND_READ);
  assign step     = busy && (tick_inc >= limit);
  assign cur_seg  = seg_lookup(is_read, seg_idx);
  assign seg_end  = (seg_off == seg_last_off(cur_seg.kind));
  assign slot_max = (cur_seg.kind == SEG_WBYTE) ? 2'd2 : 2'd1;

  always_comb begin
    busy_next     = busy;
    is_read_next  = is_read;
    addr_b_next   = addr_b;
    reg_b_next    = reg_b;
    data_b_next   = data_b;
    rx_b_next     = rx_b;
    tick_cnt_next = tick_cnt;
    seg_idx_next  = seg_idx;
    seg_off_next  = seg_off;
    slot_next     = slot;
    bit_cnt_next  = bit_cnt;
    scl_next      = scl;
    sda_next      = sda;
    done          = 1'b0;

    if (start) begin
      busy_next     = 1'b1;
      is_read_next  = (item.kind == KIND_READ);
      addr_b_next   = item.slave_address;
      reg_b_next    = item.memory_address;
      data_b_next   = (item.kind == KIND_READ) ? 8'd0 : item.write_data;
      tick_cnt_next = 16'd0;
      seg_idx_next  = 4'd0;
      seg_off_next  = 5'd0;
      slot_next     = 2'd0;
      bit_cnt_next  = 3'd0;
    end else if (busy) begin
      tick_cnt_next = step ? 16'd0 : tick_inc;
      if (step) begin
        if (seg_end) begin
          seg_idx_next = seg_idx + 4'd1;
          seg_off_next = 5'd0;
          slot_next    = 2'd0;
          bit_cnt_next = 3'd0;
        end else begin
          seg_off_next = seg_off + 5'd1;
          if (slot == slot_max) begin
            slot_next    = 2'd0;
            bit_cnt_next = bit_cnt + 3'd1;
          end else begin
            slot_next = slot + 2'd1;
          end
        end
      end
    end

    new_seg = seg_lookup(is_read_next, seg_idx_next);
    bit_sel = 3'd7 - bit_cnt_next;
    case (new_seg.src)
      SRC_ADDR: src_byte = addr_b_next;
      SRC_REG:  src_byte = reg_b_next;
      SRC_DATA: src_byte = data_b_next;
      default:  src_byte = addr_b_next | 8'd1;
    endcase

    // Apply the phase just reached
    if (start || step) begin
      unique case (new_seg.kind)
        SEG_START: begin
          if (seg_off_next == 5'd0) scl_next = 1'b1;
          else if (seg_off_next == 5'd1) sda_next = 1'b1;
          else sda_next = 1'b0;
        end
        SEG_WBYTE: begin
          if (slot_next == 2'd0) scl_next = 1'b0;
          else if (slot_next == 2'd1) sda_next = src_byte[bit_sel];
          else scl_next = 1'b1;
        end
        SEG_ACK: begin
          if (seg_off_next == 5'd0 || seg_off_next == 5'd7) scl_next = 1'b0;
          else if (seg_off_next == 5'd1) sda_next = 1'b1;
          else if (seg_off_next == 5'd2) scl_next = 1'b1;
        end
        SEG_READ: begin
          if (slot_next == 2'd0) begin
            scl_next = 1'b1;
            if (item.sda_in) data_b_next[bit_sel] = 1'b1;
          end else begin
            scl_next = 1'b0;
          end
        end
        SEG_NACK: begin
          if (seg_off_next == 5'd0) scl_next = 1'b0;
          else if (seg_off_next == 5'd1) sda_next = 1'b1;
          else scl_next = 1'b1;
        end
        default: begin
          if (seg_off_next == 5'd0) scl_next = 1'b0;
          else if (seg_off_next == 5'd1) sda_next = 1'b0;
          else if (seg_off_next == 5'd2) scl_next = 1'b1;
          else sda_next = 1'b1;
        end
      endcase
    end

    // Last stop phase: drop back to idle
    if (step && new_seg.kind == SEG_STOP && seg_off_next == 5'd3 &&
        seg_idx_next == (is_read ? RD_LAST_SEG : WR_LAST_SEG)) begin
      done         = 1'b1;
      busy_next    = 1'b0;
      seg_idx_next = 4'd0;
      seg_off_next = 5'd0;
      slot_next    = 2'd0;
      bit_cnt_next = 3'd0;
      if (is_read) rx_b_next = data_b_next;
    end
  end

  assign result = '{scl: scl_next, sda: sda_next, busy_res: busy_next,
                    done_res: done, read_data: rx_b_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= 16'd1;
    end else if (cfg_wr_en) begin
      ticks_per_phase <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      is_read  <= 1'b0;
      addr_b   <= 8'd0;
      reg_b    <= 8'd0;
      data_b   <= 8'd0;
      rx_b     <= 8'd0;
      tick_cnt <= 16'd0;
      seg_idx  <= 4'd0;
      seg_off  <= 5'd0;
      slot     <= 2'd0;
      bit_cnt  <= 3'd0;
      scl      <= 1'b1;
      sda      <= 1'b1;
    end else if (adv) begin
      busy     <= busy_next;
      is_read  <= is_read_next;
      addr_b   <= addr_b_next;
      reg_b    <= reg_b_next;
      data_b   <= data_b_next;
      rx_b     <= rx_b_next;
      tick_cnt <= tick_cnt_next;
      seg_idx  <= seg_idx_next;
      seg_off  <= seg_off_next;
      slot     <= slot_next;
      bit_cnt  <= bit_cnt_next;
      scl      <= scl_next;
      sda      <= sda_next;
    end
  end

`ifndef SYNTH
  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (seg_idx == 4'd0 && seg_off == 5'd0 && tick_cnt == 16'd0))
    else $error("idle with frame position not cleared");

  a_end_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (adv && busy && !busy_next) |-> done)
    else $error("frame ended without done");

  a_done_is_step: assert property (@(posedge clk) disable iff (rst)
    done |-> (step && tick_cnt_next == 16'd0))
    else $error("done outside a phase step");
`endif

endmodule

@@ rtl/i2c_master_byte_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_frame_sequencer
// I2C master sequencing single-byte register write and read frames.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request items. kind 0 is a tick, 1 starts a write frame
//          (start, address, register, data, stop), 2 starts a read frame
//          (start, address, register, repeated start, address|1, eight bits,
//          nack, stop). Requests while a frame runs count as ticks.
//   res  : one result item per request item: SCL level, SDA drive, busy,
//          done pulse on the last stop phase, last byte read.
//   cfg  : cfg_wr_en/cfg_wr_data set ticks_per_phase (0 acts as 1); write
//          it only while idle.
// Timing: each item's result is registered and appears in the cycle after
// acceptance; one item is taken every cycle while the result is drained.
// A write frame spans 103 phases, a read frame 125, each phase held for
// ticks_per_phase items.
// Reset: no result pending, both lines released high, ticks_per_phase 1.
// Stall: while a result waits and res.ready is low, req.ready is low and
// the result holds.
// ----------------------------------------------------------------------------
module i2c_master_byte_frame_sequencer (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  i2cbfs_req_if.sink   req,
  i2cbfs_res_if.source res
);
  import i2cbfs_pkg::*;

  logic   adv;
  res_t   step_res;
  logic   res_valid;
  res_t   res_data;

  assign req.ready = !res_valid || res.ready;
  assign adv       = req.valid && req.ready;

  i2cbfs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .item        (req.data),
    .result      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= step_res;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> res.valid)
    else $error("accepted item produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.done_res) |-> !res.data.busy_res)
    else $error("done reported while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (res.data == $past(step_res)))
    else $error("result register not loaded from step");
`endif

endmodule
